FILE: src/bpa_pkg.sv
package bpa_pkg;

    // Bitmap word: pages per memory word
    localparam int WORD_BITS = 16;
    localparam int WORD_LW   = 4;

    // Field widths
    localparam int CNT_W      = 13;
    localparam int PAGE_W     = 12;
    localparam int BYTE_ADR_W = 24;
    localparam int USED_W     = 25;

    localparam int NUM_PAGES_DEF  = 4096;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic              op;
        logic [CNT_W-1:0]  page_count;
        logic [PAGE_W-1:0] first_page;
    } bpa_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [PAGE_W-1:0]     found_page;
        logic [BYTE_ADR_W-1:0] byte_address;
        logic [USED_W-1:0]     used_bytes;
    } bpa_out_t;

    // Per-word search result
    typedef struct packed {
        logic               hit;
        logic [WORD_LW-1:0] hit_bit;
        logic               all_free;
        logic [WORD_LW:0]   top_run;
    } bpa_scan_t;

endpackage

FILE: src/bitmap_page_allocator.sv
// Bitmap first-fit page allocator.
// Input channel s_valid/s_ready/s_data carries one request word: allocate
// page_count contiguous pages, or free page_count pages from first_page.
// Output channel m_valid/m_ready/m_data returns one result word per request:
// status, first page and byte address of an allocated run, and used bytes.
// The bitmap lives in one RAM of 16-bit words with one read and one write
// port; every search and mark step moves one bitmap word per cycle.
// Allocate scans words up to the run end, then sets the bits in the words
// the run spans; free clears the bits in the words it spans. Bad count, bad
// range, or a count above NUM_PAGES go straight to the response state.
// One request is in work at a time; s_ready is high only when idle.
// After reset the RAM is cleared one word per cycle with s_ready low; the
// used count resets to zero.
// The result sits in an output register; a stalled receiver holds it, and
// the next request can be taken meanwhile, waiting at the end of its work
// until the register is free.
module bitmap_page_allocator #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bpa_pkg::bpa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bpa_pkg::bpa_out_t m_data
);

    localparam int W         = bpa_pkg::WORD_BITS;
    localparam int LW        = bpa_pkg::WORD_LW;
    localparam int CW        = bpa_pkg::CNT_W;
    localparam int DEPTH     = (NUM_PAGES + W - 1) / W;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PGW       = AW + LW;
    localparam int TW        = $clog2(NUM_PAGES + 1);
    localparam int PBW       = $clog2(PAGE_BYTES + 1);
    localparam int PRA       = PGW + PBW;
    localparam int PRU       = TW + PBW;
    localparam int PRM       = (PRA > PRU) ? PRA : PRU;
    localparam int PRW       = (PRM > bpa_pkg::USED_W) ? PRM : bpa_pkg::USED_W;
    localparam int LAST_BITS = NUM_PAGES - (DEPTH - 1) * W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [W-1:0]  LAST_MASK = {W{1'b1}} >> (W - LAST_BITS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_PREP  = 6'b001000,
        S_MARK  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     carry_reg, carry_next;
    logic [1:0]        status_reg, status_next;
    logic [PGW-1:0]    hi_page_reg, hi_page_next;
    logic [PGW-1:0]    lo_page_reg, lo_page_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              issue_reg, issue_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]     pipe_addr_reg, pipe_addr_next;
    logic              m_valid_reg, m_valid_next;
    bpa_pkg::bpa_out_t m_data_reg, m_data_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [W-1:0]  mem_wdata, mem_rdata;

    logic [W-1:0]       scan_word;
    logic [CW-1:0]      need;
    bpa_pkg::bpa_scan_t scan_res;

    logic [31:0]    free_end;
    logic [AW-1:0]  lo_word, hi_word;
    logic [W-1:0]   lo_mask, hi_mask, run_mask;
    logic [PRW-1:0] addr_prod, used_prod;

    bpa_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // pages past the end of the map read as used
    assign scan_word = (pipe_addr_reg == LAST_ADDR) ? (mem_rdata | ~LAST_MASK) : mem_rdata;
    assign need      = cnt_reg - carry_reg;

    bpa_word_scan u_scan (
        .used_word  (scan_word),
        .page_count (cnt_reg),
        .need       (need),
        .res        (scan_res)
    );

    assign free_end = 32'(s_data.first_page) + 32'(s_data.page_count);

    assign lo_word  = lo_page_reg[PGW-1:LW];
    assign hi_word  = hi_page_reg[PGW-1:LW];
    assign lo_mask  = (pipe_addr_reg == lo_word) ? ({W{1'b1}} << lo_page_reg[LW-1:0])
                                                 : {W{1'b1}};
    assign hi_mask  = (pipe_addr_reg == hi_word) ? ({W{1'b1}} >> ~hi_page_reg[LW-1:0])
                                                 : {W{1'b1}};
    assign run_mask = lo_mask & hi_mask;

    assign addr_prod = PRW'(lo_page_reg) * PRW'(PAGE_BYTES);
    assign used_prod = PRW'(total_reg) * PRW'(PAGE_BYTES);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        carry_next      = carry_reg;
        status_next     = status_reg;
        hi_page_next    = hi_page_reg;
        lo_page_next    = lo_page_reg;
        total_next      = total_reg;
        rd_addr_next    = rd_addr_reg;
        issue_next      = issue_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = pipe_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = rd_addr_reg;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_reg;
                if (rd_addr_reg == LAST_ADDR) begin
                    rd_addr_next = '0;
                    state_next   = S_IDLE;
                end else begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.op;
                    cnt_next     = s_data.page_count;
                    carry_next   = '0;
                    rd_addr_next = '0;
                    issue_next   = 1'b1;
                    lo_page_next = '0;
                    status_next  = bpa_pkg::ST_OK;
                    if (s_data.page_count == '0) begin
                        status_next = bpa_pkg::ST_BAD;
                        state_next  = S_RESP;
                    end else if (s_data.op == bpa_pkg::OP_ALLOC) begin
                        if (32'(s_data.page_count) > 32'(NUM_PAGES)) begin
                            status_next = bpa_pkg::ST_NOSPACE;
                            state_next  = S_RESP;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (free_end > 32'(NUM_PAGES)) begin
                        status_next = bpa_pkg::ST_BAD;
                        state_next  = S_RESP;
                    end else begin
                        hi_page_next = PGW'(free_end - 32'd1);
                        state_next   = S_PREP;
                    end
                end
            end
            S_SCAN: begin
                if (issue_reg) begin
                    mem_re = 1'b1;
                    if (rd_addr_reg == LAST_ADDR) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (pipe_valid_reg) begin
                    if (scan_res.hit) begin
                        hi_page_next = {pipe_addr_reg, scan_res.hit_bit};
                        issue_next   = 1'b0;
                        state_next   = S_PREP;
                    end else if (pipe_addr_reg == LAST_ADDR) begin
                        status_next = bpa_pkg::ST_NOSPACE;
                        state_next  = S_RESP;
                    end else if (scan_res.all_free) begin
                        carry_next = CW'({1'b0, carry_reg} + (CW + 1)'(W));
                    end else begin
                        carry_next = CW'(scan_res.top_run);
                    end
                end
            end
            S_PREP: begin
                lo_page_next = PGW'(32'(hi_page_reg) + 32'd1 - 32'(cnt_reg));
                rd_addr_next = lo_page_next[PGW-1:LW];
                issue_next   = 1'b1;
                if (op_reg == bpa_pkg::OP_ALLOC) begin
                    total_next = TW'(32'(total_reg) + 32'(cnt_reg));
                end else if (32'(total_reg) > 32'(cnt_reg)) begin
                    total_next = TW'(32'(total_reg) - 32'(cnt_reg));
                end else begin
                    total_next = '0;
                end
                state_next = S_MARK;
            end
            S_MARK: begin
                if (issue_reg) begin
                    mem_re = 1'b1;
                    if (rd_addr_reg == hi_word) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                // write back the word read last cycle; next read is another word
                if (pipe_valid_reg) begin
                    mem_we = 1'b1;
                    if (op_reg == bpa_pkg::OP_FREE) begin
                        mem_wdata = mem_rdata & ~run_mask;
                    end else begin
                        mem_wdata = mem_rdata | run_mask;
                    end
                    if (pipe_addr_reg == hi_word) begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.status  = status_reg;
                    m_data_next.used_bytes = used_prod[bpa_pkg::USED_W-1:0];
                    if (status_reg == bpa_pkg::ST_OK && op_reg == bpa_pkg::OP_ALLOC) begin
                        m_data_next.found_page   = bpa_pkg::PAGE_W'(lo_page_reg);
                        m_data_next.byte_address = addr_prod[bpa_pkg::BYTE_ADR_W-1:0];
                    end else begin
                        m_data_next.found_page   = '0;
                        m_data_next.byte_address = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        pipe_valid_next = mem_re;
        pipe_addr_next  = mem_raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            rd_addr_reg    <= '0;
            issue_reg      <= 1'b0;
            pipe_valid_reg <= 1'b0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_addr_reg    <= rd_addr_next;
            issue_reg      <= issue_next;
            pipe_valid_reg <= pipe_valid_next;
            total_reg      <= total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        cnt_reg       <= cnt_next;
        carry_reg     <= carry_next;
        status_reg    <= status_next;
        hi_page_reg   <= hi_page_next;
        lo_page_reg   <= lo_page_next;
        pipe_addr_reg <= pipe_addr_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/bpa_bitmap_ram.sv
module bpa_bitmap_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [bpa_pkg::WORD_BITS-1:0]  rdata
);

    logic [bpa_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [bpa_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bpa_word_scan.sv
module bpa_word_scan (
    input  logic [bpa_pkg::WORD_BITS-1:0] used_word,
    input  logic [bpa_pkg::CNT_W-1:0]     page_count,
    input  logic [bpa_pkg::CNT_W-1:0]     need,
    output bpa_pkg::bpa_scan_t            res
);

    localparam int W  = bpa_pkg::WORD_BITS;
    localparam int LW = bpa_pkg::WORD_LW;
    localparam int CW = bpa_pkg::CNT_W;

    logic [W-1:0] hit_vec;

    // A run ends at bit j either wholly inside the word, or continuing the
    // free run carried in from lower words (need = count - carry).
    for (genvar j = 0; j < W; j++) begin : g_bit
        localparam logic [W-1:0] PRE = {W{1'b1}} >> (W - 1 - j);
        logic [W-1:0] win;
        assign win = PRE & ~(PRE >> page_count);
        assign hit_vec[j] =
            ((page_count <= CW'(j + 1)) && ((used_word & win) == '0)) ||
            ((need <= CW'(j + 1)) && ((used_word & PRE) == '0));
    end

    always_comb begin
        res          = '0;
        res.all_free = (used_word == '0);
        res.top_run  = (LW + 1)'(W);
        for (int j = 0; j < W; j++) begin
            if (used_word[j]) begin
                res.top_run = (LW + 1)'(W - 1 - j);
            end
        end
        for (int j = W - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                res.hit     = 1'b1;
                res.hit_bit = LW'(j);
            end
        end
    end

endmodule

FILE: src/bpa_checker.sv
module bpa_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input bpa_pkg::bpa_out_t m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_fail_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != bpa_pkg::ST_OK |->
            m_data.found_page == '0 && m_data.byte_address == '0)
        else $error("failed result carries a page");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == bpa_pkg::ST_OK || m_data.status == bpa_pkg::ST_NOSPACE
                    || m_data.status == bpa_pkg::ST_BAD)
        else $error("undefined status code");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output or input live right after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: test/testbench.sv
module testbench;
    import bpa_pkg::*;

    localparam int NUM_PAGES     = NUM_PAGES_DEF;
    localparam int PAGE_BYTES    = PAGE_BYTES_DEF;
    localparam int RANDOM_WORDS  = 630;
    localparam int DRAIN_CYCLES  = 600;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic              typed;
        logic              op;
        logic [CNT_W-1:0]  count;
        logic [PAGE_W-1:0] first;
        bpa_out_t          result;
    } directed_row_t;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } page_run_t;

    // Rows with typed = 0 are checked against the predictor only.
    localparam int NUM_ROWS = 23;
    localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b1, OP_ALLOC, 13'd0,    12'd0,    '{ST_BAD,     12'd0,    24'd0,        25'd0}},
        '{1'b1, OP_FREE,  13'd0,    12'd4095, '{ST_BAD,     12'd0,    24'd0,        25'd0}},
        '{1'b1, OP_ALLOC, 13'd1,    12'd4095, '{ST_OK,      12'd0,    24'd0,        25'd4096}},
        '{1'b1, OP_ALLOC, 13'd4096, 12'd0,    '{ST_NOSPACE, 12'd0,    24'd0,        25'd4096}},
        '{1'b1, OP_ALLOC, 13'd8191, 12'd4095, '{ST_NOSPACE, 12'd0,    24'd0,        25'd4096}},
        '{1'b1, OP_ALLOC, 13'd4097, 12'd0,    '{ST_NOSPACE, 12'd0,    24'd0,        25'd4096}},
        '{1'b1, OP_FREE,  13'd2,    12'd4095, '{ST_BAD,     12'd0,    24'd0,        25'd4096}},
        '{1'b1, OP_FREE,  13'd8191, 12'd0,    '{ST_BAD,     12'd0,    24'd0,        25'd4096}},
        '{1'b1, OP_FREE,  13'd4096, 12'd0,    '{ST_OK,      12'd0,    24'd0,        25'd0}},
        '{1'b1, OP_ALLOC, 13'd4096, 12'd0,    '{ST_OK,      12'd0,    24'd0,        25'd16777216}},
        '{1'b1, OP_ALLOC, 13'd1,    12'd0,    '{ST_NOSPACE, 12'd0,    24'd0,        25'd16777216}},
        '{1'b1, OP_FREE,  13'd1,    12'd4095, '{ST_OK,      12'd0,    24'd0,        25'd16773120}},
        '{1'b1, OP_ALLOC, 13'd1,    12'd0,    '{ST_OK,      12'd4095, 24'd16773120, 25'd16777216}},
        '{1'b1, OP_FREE,  13'd4096, 12'd0,    '{ST_OK,      12'd0,    24'd0,        25'd0}},
        '{1'b1, OP_FREE,  13'd5,    12'd100,  '{ST_OK,      12'd0,    24'd0,        25'd0}},
        '{1'b0, OP_ALLOC, 13'd3,    12'd0,    '0},
        '{1'b0, OP_ALLOC, 13'd5,    12'd0,    '0},
        '{1'b0, OP_FREE,  13'd1,    12'd1,    '0},
        '{1'b0, OP_ALLOC, 13'd2,    12'd0,    '0},
        '{1'b0, OP_ALLOC, 13'd1,    12'd0,    '0},
        '{1'b0, OP_FREE,  13'd2,    12'd4094, '0},
        '{1'b0, OP_ALLOC, 13'd4086, 12'd0,    '0},
        '{1'b0, OP_FREE,  13'd4096, 12'd0,    '0}
    };

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bpa_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bpa_out_t m_data;

    bit        page_busy [NUM_PAGES];
    int        used_pages;
    bpa_out_t  expected_results [$];
    page_run_t live_runs [$];

    int send_idle_pct = 34;
    int recv_idle_pct = 68;
    int error_count   = 0;
    int words_sent    = 0;
    int allocs_placed = 0;
    int allocs_refused = 0;
    int frees_done    = 0;
    int words_rejected = 0;

    bitmap_page_allocator i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #24000000;
        $display("testbench: errors");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // First-fit alloc or free on the shadow bitmap; updates the shadow.
    function automatic bpa_out_t apply_page_request(input bpa_in_t req);
        bpa_out_t res;
        int       cnt;
        int       fp;
        int       run_len;
        int       run_start;
        int       hit_start;
        res       = '0;
        cnt       = req.page_count;
        fp        = req.first_page;
        run_len   = 0;
        run_start = 0;
        hit_start = -1;
        if (cnt == 0) begin
            res.status = ST_BAD;
        end else if (req.op == OP_ALLOC) begin
            if (cnt <= NUM_PAGES) begin
                for (int p = 0; p < NUM_PAGES && hit_start < 0; p++) begin
                    if (page_busy[p]) begin
                        run_len = 0;
                    end else begin
                        if (run_len == 0) run_start = p;
                        run_len++;
                        if (run_len == cnt) hit_start = run_start;
                    end
                end
            end
            if (hit_start >= 0) begin
                for (int p = 0; p < cnt; p++) page_busy[hit_start + p] = 1'b1;
                used_pages += cnt;
                res.found_page   = PAGE_W'(hit_start);
                res.byte_address = BYTE_ADR_W'(hit_start * PAGE_BYTES);
            end else begin
                res.status = ST_NOSPACE;
            end
        end else if (fp + cnt > NUM_PAGES) begin
            res.status = ST_BAD;
        end else begin
            for (int p = 0; p < cnt; p++) page_busy[fp + p] = 1'b0;
            used_pages = (used_pages > cnt) ? used_pages - cnt : 0;
        end
        res.used_bytes = USED_W'(used_pages * PAGE_BYTES);
        return res;
    endfunction

    // Mostly small allocations and frees of runs handed out earlier; the
    // medium sizes fill the map now and then so that searches fail.
    function automatic bpa_in_t next_random_request();
        bpa_in_t   req;
        page_run_t run;
        int        pick;
        int        idx;
        int        span;
        req            = '0;
        req.first_page = PAGE_W'($urandom_range(NUM_PAGES - 1));
        pick           = $urandom_range(99);
        if (pick >= 60 && pick < 85 && live_runs.size() == 0) pick = 0;
        if (pick < 50) begin
            req.op         = OP_ALLOC;
            req.page_count = CNT_W'($urandom_range(16, 1));
        end else if (pick < 58) begin
            req.op         = OP_ALLOC;
            req.page_count = CNT_W'($urandom_range(1024, 17));
        end else if (pick < 60) begin
            req.op         = OP_ALLOC;
            req.page_count = CNT_W'($urandom_range(8191, 1));
        end else if (pick < 85) begin
            idx = $urandom_range(live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            req.op         = OP_FREE;
            req.first_page = run.start;
            req.page_count = run.count;
        end else if (pick < 90) begin
            span           = NUM_PAGES - req.first_page;
            req.op         = OP_FREE;
            req.page_count = CNT_W'($urandom_range((span < 64) ? span : 64, 1));
        end else if (pick < 94) begin
            req.op         = OP_FREE;
            req.page_count = CNT_W'($urandom_range(8191, NUM_PAGES + 1 - req.first_page));
        end else if (pick < 99) begin
            req.op         = 1'($urandom_range(1));
            req.page_count = '0;
        end else begin
            req.op         = OP_FREE;
            req.first_page = '0;
            req.page_count = CNT_W'(NUM_PAGES);
        end
        return req;
    endfunction

    task automatic send_request(input bpa_in_t req, input logic typed,
                                input bpa_out_t typed_result);
        bpa_out_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = apply_page_request(req);
        expected_results.push_back(typed ? typed_result : predicted);
        words_sent++;
        if (predicted.status == ST_BAD) begin
            words_rejected++;
        end else if (predicted.status == ST_NOSPACE) begin
            allocs_refused++;
        end else if (req.op == OP_ALLOC) begin
            allocs_placed++;
            live_runs.push_back('{predicted.found_page, req.page_count});
        end else begin
            frees_done++;
            if (req.page_count == NUM_PAGES) live_runs.delete();
        end
    endtask

    task automatic note_failure(input string what, input bpa_out_t want, input bpa_out_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $write("%0t: %s: expected status %0d page %0d addr %0d used %0d",
                   $realtime, what, want.status, want.found_page, want.byte_address,
                   want.used_bytes);
            $display(", got status %0d page %0d addr %0d used %0d",
                     got.status, got.found_page, got.byte_address, got.used_bytes);
        end
    endtask

    always @(posedge aclk) begin
        bpa_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_results.size() == 0) begin
                note_failure("result word with nothing pending", '0, m_data);
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status || m_data.found_page !== want.found_page ||
                    m_data.byte_address !== want.byte_address ||
                    m_data.used_bytes !== want.used_bytes)
                    note_failure("result word mismatch", want, m_data);
            end
        end
    end

    initial begin
        bpa_in_t req;
        for (int i = 0; i < NUM_PAGES; i++) page_busy[i] = 1'b0;
        used_pages = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            req.op         = DIRECTED_ROWS[i].op;
            req.page_count = DIRECTED_ROWS[i].count;
            req.first_page = DIRECTED_ROWS[i].first;
            send_request(req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 34; recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int i = 0; i < RANDOM_WORDS / 3; i++) begin
                req = next_random_request();
                send_request(req, 1'b0, '0);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            note_failure("results never arrived", expected_results[0], '0);

        $display("summary: %0d words sent; %0d runs placed, %0d refused for lack of space",
                 words_sent, allocs_placed, allocs_refused);
        $display("summary: %0d frees done, %0d bad count or range, %0d mismatches",
                 frees_done, words_rejected, error_count);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
